// File: sv/rdw_pkg.sv
// Package with the types and constants shared by the wipe engine modules.
package rdw_pkg;

	localparam int COLUMNS_DEF = 68;
	localparam int ROWS_DEF = 140;
	localparam int PICTURE_COUNT_DEF = 30;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_ACT = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_FRAME = 2'd1;
	localparam logic [1:0] CMD_SLIDE = 2'd2;
	localparam logic [1:0] CMD_PAUSE = 2'd3;

	localparam logic [0:0] REG_DURATION = 1'd0;
	localparam logic [0:0] REG_STEP = 1'd1;

	localparam logic [15:0] DURATION_RESET = 16'd1000;
	localparam logic [9:0] STEP_RESET = 10'd50;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] seed;
		logic idle_now;
		logic [6:0] column;
		logic [7:0] row;
		logic ink_current;
		logic ink_next;
	} in_item_t;

	typedef struct packed {
		logic pixel_on;
		logic [1:0] timer_command;
		logic [4:0] current_picture;
		logic [4:0] next_picture;
		logic in_transition;
	} out_item_t;

	function automatic logic [31:0] xorshift(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

// File: sv/rdw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rdw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 68
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/rdw_queue.sv
// Two-entry request queue between the front and the back.
module rdw_queue
	import rdw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input in_item_t wdata,
	input logic pop,
	output logic full,
	output logic empty,
	output in_item_t rdata
);
	in_item_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: sv/rdw_front.sv
// Front end: accepts requests and normalizes the mode-specific fields into the queue.
module rdw_front
	import rdw_pkg::*;
(
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic push,
	output in_item_t push_data,
	input logic q_full
);
	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	// Only pixel queries carry a position, so the column and row of other requests are cleared.
	always_comb begin
		push_data = in_data;
		if (in_data.mode != MODE_QUERY) begin
			push_data.column = '0;
			push_data.row = '0;
		end
	end
endmodule

// File: sv/rdw_divider.sv
// Restoring divider: 33-bit quotient of a 33-bit dividend by a 17-bit divisor.
module rdw_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [32:0] dividend,
	input logic [16:0] divisor,
	output logic done,
	output logic [32:0] quotient
);
	logic [32:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] div_q;
	logic [5:0] cnt_q;
	logic [17:0] trial;
	logic [17:0] shifted;
	logic busy;

	assign shifted = {rem_q[16:0], quo_q[32]};
	assign trial = shifted - {1'b0, div_q};
	assign busy = cnt_q != 6'd0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
			done <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
				cnt_q <= 6'd33;
			end else if (busy) begin
				if (!trial[17]) begin
					rem_q <= trial;
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// File: sv/rdw_back.sv
// Back end: state machine that carries out requests, with delay RAM and divider.
module rdw_back
	import rdw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	parameter int PICTURE_COUNT = PICTURE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input in_item_t q_data,
	output logic pop,
	input logic [15:0] duration,
	input logic [9:0] step,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW = $clog2(ROWS + 5);
	localparam logic [28:0] RECIP_1K = 29'd274877907;
	localparam int PIC_BITS = (PICTURE_COUNT > 1) ? $clog2(PICTURE_COUNT) : 1;
	localparam int PIC_SHIFT = 32 + PIC_BITS;
	localparam logic [32:0] RECIP_PIC = 33'(((65'd1 << PIC_SHIFT) + 65'(PICTURE_COUNT)
		- 65'd1) / 65'(PICTURE_COUNT));

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_RND = 11'b00000000010,
		ST_QUO = 11'b00000000100,
		ST_REM = 11'b00000001000,
		ST_WR = 11'b00000010000,
		ST_RDEL = 11'b00000100000,
		ST_DIVP = 11'b00001000000,
		ST_WAITP = 11'b00010000000,
		ST_DIVU = 11'b00100000000,
		ST_WAITU = 11'b01000000000,
		ST_OUT = 11'b10000000000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [4:0] cur_q, nxt_q;
	logic act_q, idle_q;
	logic [15:0] elapsed_q;
	logic [31:0] rng_q;
	logic [CW:0] fill_q;
	logic [16:0] p_q, d_q;
	logic [1:0] cmd_q;
	logic pix_q;
	logic [31:0] quo_q;
	logic [9:0] rmod_q;

	logic ram_we;
	logic [CW-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;

	logic div_start, div_done;
	logic [32:0] div_dividend, div_quot;
	logic [16:0] div_divisor;

	logic [31:0] rng_n;
	logic [60:0] prod_1k;
	logic [64:0] prod_pic;
	logic [38:0] prod_scale;
	logic [31:0] rem_1k;
	logic [31:0] rem_pic;
	logic [16:0] u_sat;
	logic [26:0] depth_prod;
	logic [RW-1:0] depth;
	logic [16:0] elapsed_sum;
	logic [4:0] cur_inc;
	logic col_ok;
	logic pix_val;

	rdw_ram #(.WIDTH(16), .DEPTH(COLUMNS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	rdw_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quot)
	);

	assign rng_n = xorshift(rng_q);
	// Residues come from a reciprocal multiply for the quotient, then a subtract of
	// quotient times the modulus in the next state.
	assign prod_1k = 61'(rng_q) * 61'(RECIP_1K);
	assign prod_pic = 65'(rng_q) * 65'(RECIP_PIC);
	assign rem_1k = rng_q - quo_q * 32'd1000;
	assign rem_pic = rng_q - quo_q * 32'(PICTURE_COUNT);
	// The delay r * 32768 / 1000 uses the same reciprocal with the shift reduced by 15.
	assign prod_scale = 39'(rmod_q) * 39'(RECIP_1K);
	assign cur_inc = (cur_q == 5'(PICTURE_COUNT - 1)) ? 5'd0 : cur_q + 5'd1;
	assign ram_we = state_q == ST_WR;
	assign ram_waddr = fill_q[CW-1:0];
	assign ram_wdata = prod_scale[38:23];
	assign col_ok = {2'b0, item_q.column} < 9'(COLUMNS);
	assign ram_raddr = col_ok ? CW'(item_q.column) : '0;
	assign elapsed_sum = {1'b0, elapsed_q} + {7'd0, step};

	assign u_sat = (div_quot > 33'd65536) ? 17'd65536 : div_quot[16:0];
	assign depth_prod = 27'({10'd0, u_sat} * 27'(ROWS + 1));
	assign depth = RW'(depth_prod >> 16);

	always_comb begin
		logic [RW-1:0] rowx;
		rowx = RW'(item_q.row);
		if (RW < 8 && item_q.row > 8'((1 << RW) - 1)) begin
			rowx = '1;
		end
		pix_val = (rowx < depth) ? item_q.ink_next : item_q.ink_current;
		if (depth != '0 && depth <= RW'(ROWS) && ({1'b0, item_q.row} == 9'(depth)
				|| {1'b0, item_q.row} == 9'(depth) + 9'd3)) begin
			pix_val = 1'b1;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_dividend = {1'b0, elapsed_q, 16'd0};
		div_divisor = {1'b0, duration};
		if (state_q == ST_DIVP) begin
			div_start = 1'b1;
		end else if (state_q == ST_DIVU) begin
			div_start = 1'b1;
			div_dividend = {(p_q - d_q), 16'd0};
			div_divisor = 17'd65536 - d_q;
		end
	end

	assign pop = state_q == ST_IDLE && !q_empty;
	assign out_valid = state_q == ST_OUT;
	assign out_data = '{pixel_on: pix_q, timer_command: cmd_q, current_picture: cur_q,
		next_picture: nxt_q, in_transition: act_q};

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			nxt_q <= '0;
			act_q <= 1'b0;
			idle_q <= 1'b0;
			elapsed_q <= '0;
			rng_q <= 32'd1;
			fill_q <= '0;
			p_q <= '0;
			d_q <= '0;
			cmd_q <= CMD_NONE;
			pix_q <= 1'b0;
			quo_q <= '0;
			rmod_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pix_q <= 1'b0;
						cmd_q <= CMD_NONE;
						state_q <= ST_OUT;
						case (q_data.mode)
							MODE_INIT: begin
								rng_q <= xorshift(q_data.seed | 32'd1);
								act_q <= 1'b0;
								elapsed_q <= '0;
								cmd_q <= CMD_SLIDE;
								state_q <= ST_QUO;
							end
							MODE_TICK: begin
								if (!idle_q) begin
									if (!act_q) begin
										nxt_q <= cur_inc;
										act_q <= 1'b1;
										elapsed_q <= '0;
										fill_q <= '0;
										cmd_q <= CMD_FRAME;
										state_q <= ST_RND;
									end else begin
										elapsed_q <= elapsed_sum[16] ? 16'hFFFF
											: elapsed_sum[15:0];
										if ((elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0])
												>= duration) begin
											cur_q <= nxt_q;
											act_q <= 1'b0;
											cmd_q <= CMD_SLIDE;
										end
									end
								end
							end
							MODE_ACT: begin
								idle_q <= q_data.idle_now;
								if (q_data.idle_now) begin
									cmd_q <= CMD_PAUSE;
								end else if (idle_q) begin
									if (act_q) begin
										cur_q <= nxt_q;
										act_q <= 1'b0;
									end
									cmd_q <= CMD_SLIDE;
								end
							end
							default: begin
								if (idle_q) begin
									pix_q <= 1'b0;
								end else if (!act_q) begin
									pix_q <= q_data.ink_current;
								end else begin
									state_q <= ST_RDEL;
								end
							end
						endcase
					end
				end
				ST_RND: begin
					rng_q <= rng_n;
					state_q <= ST_QUO;
				end
				ST_QUO: begin
					if (item_q.mode == MODE_INIT) begin
						quo_q <= 32'(prod_pic >> PIC_SHIFT);
					end else begin
						quo_q <= {9'd0, prod_1k[60:38]};
					end
					state_q <= ST_REM;
				end
				ST_REM: begin
					if (item_q.mode == MODE_INIT) begin
						cur_q <= rem_pic[4:0];
						state_q <= ST_OUT;
					end else begin
						rmod_q <= rem_1k[9:0];
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					fill_q <= fill_q + (CW+1)'(1);
					if (fill_q == (CW+1)'(COLUMNS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RND;
					end
				end
				ST_RDEL: begin
					state_q <= ST_DIVP;
				end
				ST_DIVP: begin
					d_q <= col_ok ? {1'b0, ram_rdata} : 17'd0;
					state_q <= ST_WAITP;
				end
				ST_WAITP: begin
					if (div_done) begin
						if (duration == 16'd0 || div_quot > 33'd65536) begin
							p_q <= 17'd65536;
						end else begin
							p_q <= div_quot[16:0];
						end
						state_q <= ST_DIVU;
					end
				end
				ST_DIVU: begin
					if (p_q <= d_q) begin
						pix_q <= item_q.ink_current;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_WAITU;
					end
				end
				ST_WAITU: begin
					if (div_done) begin
						pix_q <= pix_val;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: sv/random_drip_wipe_transition_core.sv
// Top level of the random drip wipe slideshow engine.
// A tick that starts a wipe fills the delay RAM, one column per pass through the
// random, quotient, remainder and write states. A pixel query during a wipe makes two
// passes of the 33-step divider (one when the column has not started to drop). One
// request is in the back end at a time; a two-entry queue decouples the input. Reset
// is asynchronous and active low.
module random_drip_wipe_transition_core
	import rdw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	parameter int PICTURE_COUNT = PICTURE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [15:0] duration_q;
	logic [9:0] step_q;
	logic push, q_full, q_empty, pop;
	in_item_t push_data, q_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DURATION_RESET;
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_DURATION) begin
				duration_q <= pwdata[15:0];
			end else begin
				step_q <= pwdata[9:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DURATION) begin
			prdata = {16'd0, duration_q};
		end else if (paddr[2] == REG_STEP) begin
			prdata = {22'd0, step_q};
		end
	end

	rdw_front u_front (
		.in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .push(push), .push_data(push_data), .q_full(q_full)
	);

	rdw_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_data), .pop(pop),
		.full(q_full), .empty(q_empty), .rdata(q_data)
	);

	rdw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .PICTURE_COUNT(PICTURE_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_data), .pop(pop),
		.duration(duration_q), .step(step_q), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data)
	);
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the random drip wipe slideshow engine.
`timescale 1ns / 100ps

module tb_top;
	import rdw_pkg::*;

	localparam int NCOL = 68;
	localparam int NROW = 140;
	localparam int NPIC = 30;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	random_drip_wipe_transition_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state of the slideshow.
	logic [15:0] duration_ms;
	logic [9:0] step_ms;
	logic [4:0] cur_pic, nxt_pic;
	logic wiping;
	logic [15:0] elapsed;
	logic [15:0] col_delay [NCOL];
	logic [31:0] rng;
	logic idle;

	in_item_t pending_requests[$];
	out_item_t expected_results[$];
	int errors = 0;
	int checked = 0;
	int queries_in_wipe = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit in_taken = 1'b0;
	int src_gap = 0, snk_gap = 0;

	function automatic logic [31:0] rng_advance(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	function automatic logic wipe_pixel(input in_item_t q);
		logic [63:0] p, d, u, depth;
		logic ink;
		if (duration_ms == 0) p = 64'd65536;
		else begin
			p = ({48'd0, elapsed} * 64'd65536) / duration_ms;
			if (p > 64'd65536) p = 64'd65536;
		end
		d = (q.column < NCOL) ? {48'd0, col_delay[q.column]} : 64'd0;
		if (p <= d) u = 0;
		else begin
			u = ((p - d) * 64'd65536) / (64'd65536 - d);
			if (u > 64'd65536) u = 64'd65536;
		end
		depth = (u * (NROW + 1)) >> 16;
		ink = ({56'd0, q.row} < depth) ? q.ink_next : q.ink_current;
		if (depth > 0 && depth <= NROW && ({56'd0, q.row} == depth || {56'd0, q.row} == depth + 3))
			ink = 1'b1;
		return ink;
	endfunction

	task automatic predict_slideshow(input in_item_t q);
		out_item_t r;
		logic [16:0] sum;
		logic prev_idle;
		logic [31:0] v;
		r = '0;
		case (q.mode)
			MODE_INIT: begin
				rng = rng_advance(q.seed | 32'd1);
				cur_pic = 5'(rng % NPIC);
				wiping = 1'b0;
				elapsed = '0;
				r.timer_command = CMD_SLIDE;
			end
			MODE_TICK: begin
				if (!idle) begin
					if (!wiping) begin
						nxt_pic = 5'((cur_pic + 1) % NPIC);
						wiping = 1'b1;
						elapsed = '0;
						for (int c = 0; c < NCOL; c++) begin
							rng = rng_advance(rng);
							v = rng % 1000;
							col_delay[c] = 16'((v * 32768) / 1000);
						end
						r.timer_command = CMD_FRAME;
					end else begin
						sum = {1'b0, elapsed} + {7'd0, step_ms};
						elapsed = sum[16] ? 16'hFFFF : sum[15:0];
						if (elapsed >= duration_ms) begin
							cur_pic = nxt_pic;
							wiping = 1'b0;
							r.timer_command = CMD_SLIDE;
						end
					end
				end
			end
			MODE_ACT: begin
				prev_idle = idle;
				idle = q.idle_now;
				if (idle) r.timer_command = CMD_PAUSE;
				else if (prev_idle) begin
					if (wiping) begin
						cur_pic = nxt_pic;
						wiping = 1'b0;
					end
					r.timer_command = CMD_SLIDE;
				end
			end
			default: begin
				if (idle) r.pixel_on = 1'b0;
				else if (!wiping) r.pixel_on = q.ink_current;
				else begin
					r.pixel_on = wipe_pixel(q);
					queries_in_wipe++;
				end
			end
		endcase
		r.current_picture = cur_pic;
		r.next_picture = nxt_pic;
		r.in_transition = wiping;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	// Driver: a request is presented at the falling edge and held until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
			end else if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				src_gap = $urandom_range(1, 19);
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_requests[0];
			end else
				in_valid <= 1'b0;
			in_taken = 1'b0;
			if (snk_gap > 0) begin
				snk_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				snk_gap = $urandom_range(1, 19);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Monitor: results are compared and requests are taken at the rising edge.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("result with nothing expected");
				errors++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (out_data.pixel_on !== e.pixel_on)
					report_mismatch("pixel_on", out_data.pixel_on, e.pixel_on);
				if (out_data.timer_command !== e.timer_command)
					report_mismatch("timer_command", out_data.timer_command, e.timer_command);
				if (out_data.current_picture !== e.current_picture)
					report_mismatch("current_picture", out_data.current_picture,
						e.current_picture);
				if (out_data.next_picture !== e.next_picture)
					report_mismatch("next_picture", out_data.next_picture, e.next_picture);
				if (out_data.in_transition !== e.in_transition)
					report_mismatch("in_transition", out_data.in_transition, e.in_transition);
			end
			checked++;
		end
		if (arst_n && in_valid && !in_stall) begin
			predict_slideshow(in_data);
			void'(pending_requests.pop_front());
			in_taken = 1'b1;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_DURATION) duration_ms = val[15:0];
		else step_ms = val[9:0];
	endtask

	function automatic in_item_t make_req(input logic [1:0] m);
		in_item_t q;
		q = '0;
		q.mode = m;
		q.seed = $urandom;
		q.idle_now = 1'($urandom_range(0, 1));
		q.column = 7'($urandom_range(0, 127));
		q.row = 8'($urandom_range(0, 255));
		q.ink_current = 1'($urandom_range(0, 1));
		q.ink_next = 1'($urandom_range(0, 1));
		return q;
	endfunction

	task automatic push(input in_item_t q);
		pending_requests.push_back(q);
	endtask

	task automatic drain;
		while (pending_requests.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Mostly well-formed slideshow traffic: a random mix of inits, ticks, activity requests and queries.
	task automatic random_phase(input int n);
		in_item_t q;
		int k;
		for (k = 0; k < n; k++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 3) q = make_req(MODE_INIT);
			else if (pick < 20) q = make_req(MODE_TICK);
			else if (pick < 25) q = make_req(MODE_ACT);
			else q = make_req(MODE_QUERY);
			if (q.mode == MODE_ACT && $urandom_range(0, 2) != 0) q.idle_now = 1'b0;
			if (q.mode == MODE_QUERY && $urandom_range(0, 3) != 0) begin
				q.column = 7'($urandom_range(0, NCOL - 1));
				q.row = 8'($urandom_range(0, NROW));
			end
			push(q);
		end
	endtask

	initial begin
		in_item_t q;
		duration_ms = DURATION_RESET;
		step_ms = STEP_RESET;
		cur_pic = '0; nxt_pic = '0; wiping = 1'b0; elapsed = '0;
		rng = 32'd1; idle = 1'b0;
		foreach (col_delay[i]) col_delay[i] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: queries outside a wipe, init extremes, a wipe with edge queries ended by activity.
		q = make_req(MODE_QUERY); q.column = 0; q.row = 0; q.ink_current = 1; push(q);
		q = make_req(MODE_INIT); q.seed = 32'd0; push(q);
		q = make_req(MODE_INIT); q.seed = 32'hFFFFFFFF; push(q);
		q = make_req(MODE_TICK); push(q);
		q = make_req(MODE_QUERY); q.column = 0; q.row = 0; push(q);
		q = make_req(MODE_QUERY); q.column = 7'd127; q.row = 8'd255; push(q);
		q = make_req(MODE_QUERY); q.column = 67; q.row = 8'd140; push(q);
		for (int i = 0; i < 12; i++) begin
			q = make_req(MODE_TICK); push(q);
			q = make_req(MODE_QUERY); q.column = 7'(i * 5);
			q.row = 8'($urandom_range(0, NROW));
			push(q);
		end
		q = make_req(MODE_ACT); q.idle_now = 1; push(q);
		q = make_req(MODE_TICK); push(q);
		q = make_req(MODE_QUERY); push(q);
		q = make_req(MODE_ACT); q.idle_now = 1; push(q);
		q = make_req(MODE_ACT); q.idle_now = 0; push(q);
		q = make_req(MODE_ACT); q.idle_now = 0; push(q);
		drain();

		// Shortest wipes with the largest step, then the longest with the smallest.
		write_reg(REG_DURATION, 32'd50);
		write_reg(REG_STEP, 32'd1000);
		random_phase(250);
		drain();
		write_reg(REG_DURATION, 32'd65535);
		write_reg(REG_STEP, 32'd1);
		random_phase(150);
		drain();
		write_reg(REG_DURATION, 32'd300);
		write_reg(REG_STEP, 32'd7);
		random_phase(300);
		drain();
		write_reg(REG_DURATION, 32'd65535);
		write_reg(REG_STEP, 32'd1000);
		random_phase(250);
		drain();
		write_reg(REG_DURATION, 32'd1000);
		write_reg(REG_STEP, 32'd50);
		quiet = 1'b1;
		random_phase(300);
		drain();

		$display("covered %0d results, %0d of them pixel queries during a wipe",
			checked, queries_in_wipe);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
